@@ design/tdo_pkg.sv @@
// tdo_pkg: shared constants for the tick dust occupancy and LED timer.
// Register map codes, reset values, LED mode codes and the LED pin function. No dependencies.
`timescale 1ns / 1ps

package tdo_pkg;

    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned PERIOD_W = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    typedef logic [1:0] t_reg_idx;
    typedef logic [1:0] t_mode;

    localparam t_reg_idx REG_DUST_WINDOW  = 2'd0;
    localparam t_reg_idx REG_ENV_PERIOD   = 2'd1;
    localparam t_reg_idx REG_SECOND_PERIOD = 2'd2;
    localparam t_reg_idx REG_FLASH_PERIOD = 2'd3;

    localparam logic [WINDOW_W-1:0] DUST_WINDOW_RST   = 16'd931;
    localparam logic [PERIOD_W-1:0] ENV_PERIOD_RST    = 8'd31;
    localparam logic [PERIOD_W-1:0] SECOND_PERIOD_RST = 8'd31;
    localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RST  = 8'd15;

    localparam t_mode MODE_OFF   = 2'd0;
    localparam t_mode MODE_ON    = 2'd1;
    localparam t_mode MODE_FLASH = 2'd2;
    localparam t_mode MODE_HOLD  = 2'd3;

    // Next pin level for one LED given its mode and the flash event.
    function automatic logic drive_pin(logic level, t_mode mode, logic flash_tick);
        logic res;
        case (mode)
            MODE_OFF:   res = 1'b0;
            MODE_ON:    res = 1'b1;
            MODE_FLASH: res = flash_tick ? ~level : level;
            default:    res = level;
        endcase
        return res;
    endfunction

endpackage

@@ design/tdo_tick_if.sv @@
// tdo_tick_if: tick channel, one beat per timer tick.
// Carries valid, ready and the tick fields. No dependencies.
`timescale 1ns / 1ps

interface tdo_tick_if;
    logic       valid;
    logic       ready;
    logic       dust_pin_one;
    logic       dust_pin_two;
    logic [1:0] led_one_mode;
    logic [1:0] led_two_mode;
    logic       ack_dust;
    logic       ack_env;
    logic       ack_link;

    modport source (
        output valid, dust_pin_one, dust_pin_two, led_one_mode, led_two_mode,
               ack_dust, ack_env, ack_link,
        input  ready
    );
    modport sink (
        input  valid, dust_pin_one, dust_pin_two, led_one_mode, led_two_mode,
               ack_dust, ack_env, ack_link,
        output ready
    );
endinterface

@@ design/tdo_result_if.sv @@
// tdo_result_if: result channel, one beat per processed tick.
// Carries valid, ready and the result fields. No dependencies.
`timescale 1ns / 1ps

interface tdo_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] dust_count_one;
    logic [15:0] dust_count_two;
    logic        dust_ready;
    logic        env_pending;
    logic        link_check_pending;
    logic        led_one_pin;
    logic        led_two_pin;

    modport source (
        output valid, dust_count_one, dust_count_two, dust_ready, env_pending,
               link_check_pending, led_one_pin, led_two_pin,
        input  ready
    );
    modport sink (
        input  valid, dust_count_one, dust_count_two, dust_ready, env_pending,
               link_check_pending, led_one_pin, led_two_pin,
        output ready
    );
endinterface

@@ design/tick_dust_occupancy_and_led_timer.sv @@
// tick_dust_occupancy_and_led_timer: dust occupancy counter, event flags, LED driver.
// Depends on tdo_pkg, tdo_tick_if and tdo_result_if.
`timescale 1ns / 1ps

//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+----------------------------------------
//  i_tick     | in  | valid / ready  | dust pins, LED modes, acks (one tick)
//  o_result   | out | valid / ready  | latched counts, flags, LED pin levels
//  APB config | in  | psel / penable | four period registers at 4*index
//
//  A tick beat is taken into an input register, and its update is then
//  applied to the state registers, which also serve as the result register,
//  once the result stage is free. One tick per clock is sustained while the
//  result is not stalled.
//  A stalled result holds the state; the input register still takes one beat
//  while the result waits, so ready drops only when both stages are full.
//  Reset (synchronous, active low) clears all counters, flags and LED pins
//  and loads the register reset values.

module tick_dust_occupancy_and_led_timer
    import tdo_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    tdo_tick_if.sink            i_tick,
    tdo_result_if.source        o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WINDOW_W-1:0] r_dust_window;
    logic [PERIOD_W-1:0] r_env_period;
    logic [PERIOD_W-1:0] r_second_period;
    logic [PERIOD_W-1:0] r_flash_period;

    t_reg_idx cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dust_window   <= DUST_WINDOW_RST;
            r_env_period    <= ENV_PERIOD_RST;
            r_second_period <= SECOND_PERIOD_RST;
            r_flash_period  <= FLASH_PERIOD_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DUST_WINDOW:   r_dust_window   <= pwdata[WINDOW_W-1:0];
                REG_ENV_PERIOD:    r_env_period    <= pwdata[PERIOD_W-1:0];
                REG_SECOND_PERIOD: r_second_period <= pwdata[PERIOD_W-1:0];
                REG_FLASH_PERIOD:  r_flash_period  <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DUST_WINDOW:   prdata = {{(DATA_W-WINDOW_W){1'b0}}, r_dust_window};
            REG_ENV_PERIOD:    prdata = {{(DATA_W-PERIOD_W){1'b0}}, r_env_period};
            REG_SECOND_PERIOD: prdata = {{(DATA_W-PERIOD_W){1'b0}}, r_second_period};
            REG_FLASH_PERIOD:  prdata = {{(DATA_W-PERIOD_W){1'b0}}, r_flash_period};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic       r_pin_one_in;
    logic       r_pin_two_in;
    t_mode      r_mode_one;
    t_mode      r_mode_two;
    logic       r_ack_dust;
    logic       r_ack_env;
    logic       r_ack_link;

    logic       r_out_valid;
    logic       out_free;   // result stage can take a new beat
    logic       adv;        // input stage moves into the state/result stage
    logic       in_take;

    assign out_free       = !r_out_valid || o_result.ready;
    assign adv            = r_in_valid && out_free;
    assign i_tick.ready   = !r_in_valid || out_free;
    assign in_take        = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload holds whenever no new beat is taken
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pin_one_in <= i_tick.dust_pin_one;
            r_pin_two_in <= i_tick.dust_pin_two;
            r_mode_one   <= i_tick.led_one_mode;
            r_mode_two   <= i_tick.led_two_mode;
            r_ack_dust   <= i_tick.ack_dust;
            r_ack_env    <= i_tick.ack_env;
            r_ack_link   <= i_tick.ack_link;
        end
    end

    // ------------------------------------------------------------------
    // Tick state (doubles as the result register)
    // ------------------------------------------------------------------
    logic [WINDOW_W-1:0] r_window_cnt, n_window_cnt;
    logic [PERIOD_W-1:0] r_env_cnt, n_env_cnt;
    logic [PERIOD_W-1:0] r_second_cnt, n_second_cnt;
    logic [PERIOD_W-1:0] r_flash_cnt, n_flash_cnt;
    logic [COUNT_W-1:0]  r_occ_one, n_occ_one;
    logic [COUNT_W-1:0]  r_occ_two, n_occ_two;
    logic [COUNT_W-1:0]  r_latched_one, n_latched_one;
    logic [COUNT_W-1:0]  r_latched_two, n_latched_two;
    logic                r_ready_flag, n_ready_flag;
    logic                r_env_flag, n_env_flag;
    logic                r_link_flag, n_link_flag;
    logic [1:0]          r_pin_levels, n_pin_levels;

    logic [WINDOW_W-1:0] win_inc;
    logic [PERIOD_W-1:0] env_inc, sec_inc, fl_inc;
    logic [COUNT_W-1:0]  occ_one_inc, occ_two_inc;
    logic                win_fire, env_fire, sec_fire, flash_tick;

    always_comb begin
        // advance counters, saturating at full scale
        win_inc = (r_window_cnt == '1) ? r_window_cnt : r_window_cnt + 1'b1;
        env_inc = (r_env_cnt    == '1) ? r_env_cnt    : r_env_cnt + 1'b1;
        sec_inc = (r_second_cnt == '1) ? r_second_cnt : r_second_cnt + 1'b1;
        fl_inc  = (r_flash_cnt  == '1) ? r_flash_cnt  : r_flash_cnt + 1'b1;

        // count a low pin
        occ_one_inc = (!r_pin_one_in && r_occ_one != '1) ? r_occ_one + 1'b1 : r_occ_one;
        occ_two_inc = (!r_pin_two_in && r_occ_two != '1) ? r_occ_two + 1'b1 : r_occ_two;

        // a period of zero reads as reached on every tick
        win_fire   = win_inc >= r_dust_window;
        env_fire   = env_inc >= r_env_period;
        sec_fire   = sec_inc >= r_second_period;
        flash_tick = fl_inc  >= r_flash_period;

        n_window_cnt = win_fire   ? '0 : win_inc;
        n_env_cnt    = env_fire   ? '0 : env_inc;
        n_second_cnt = sec_fire   ? '0 : sec_inc;
        n_flash_cnt  = flash_tick ? '0 : fl_inc;

        n_occ_one     = win_fire ? '0 : occ_one_inc;
        n_occ_two     = win_fire ? '0 : occ_two_inc;
        n_latched_one = win_fire ? occ_one_inc : r_latched_one;
        n_latched_two = win_fire ? occ_two_inc : r_latched_two;

        // ack drops the flag first, an event on the same tick sets it again
        n_ready_flag = win_fire || (r_ready_flag && !r_ack_dust);
        n_env_flag   = env_fire || (r_env_flag   && !r_ack_env);
        n_link_flag  = sec_fire || (r_link_flag  && !r_ack_link);

        n_pin_levels[0] = drive_pin(r_pin_levels[0], r_mode_one, flash_tick);
        n_pin_levels[1] = drive_pin(r_pin_levels[1], r_mode_two, flash_tick);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_cnt  <= '0;
            r_env_cnt     <= '0;
            r_second_cnt  <= '0;
            r_flash_cnt   <= '0;
            r_occ_one     <= '0;
            r_occ_two     <= '0;
            r_latched_one <= '0;
            r_latched_two <= '0;
            r_ready_flag  <= 1'b0;
            r_env_flag    <= 1'b0;
            r_link_flag   <= 1'b0;
            r_pin_levels  <= '0;
        end else if (adv) begin
            r_window_cnt  <= n_window_cnt;
            r_env_cnt     <= n_env_cnt;
            r_second_cnt  <= n_second_cnt;
            r_flash_cnt   <= n_flash_cnt;
            r_occ_one     <= n_occ_one;
            r_occ_two     <= n_occ_two;
            r_latched_one <= n_latched_one;
            r_latched_two <= n_latched_two;
            r_ready_flag  <= n_ready_flag;
            r_env_flag    <= n_env_flag;
            r_link_flag   <= n_link_flag;
            r_pin_levels  <= n_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // drive the result beat straight from the state
    assign o_result.valid              = r_out_valid;
    assign o_result.dust_count_one     = r_latched_one;
    assign o_result.dust_count_two     = r_latched_two;
    assign o_result.dust_ready         = r_ready_flag;
    assign o_result.env_pending        = r_env_flag;
    assign o_result.link_check_pending = r_link_flag;
    assign o_result.led_one_pin        = r_pin_levels[0];
    assign o_result.led_two_pin        = r_pin_levels[1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_low_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick.ready |-> (r_in_valid && r_out_valid && !o_result.ready))
        else $error("tick ready low while a stage is free");

    a_in_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("input beat dropped without advancing");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_latched_one) && $stable(r_pin_levels)
                  && $stable(r_window_cnt)))
        else $error("state changed without a tick");

    a_latch_restarts_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready_flag) |-> (r_occ_one == '0 && r_occ_two == '0
                                 && r_window_cnt == '0))
        else $error("counts not restarted on window latch");

endmodule
